/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertions with asynchronous active-low reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define RTMF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define RTMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rtmf_pkg.sv */
// ----------------------------------------------------------------------------
// rtmf_pkg
// shared types, widths and codes of the ratio test match filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtmf_pkg;

	localparam int unsigned TABLE_DEPTH     = 256;
	localparam int unsigned NUM_IMAGES      = 64;
	localparam int unsigned TRAIN_PER_IMAGE = 1024;

	localparam int unsigned QUERY_W   = 8;
	localparam int unsigned IMG_W     = $clog2(NUM_IMAGES);
	localparam int unsigned TRAIN_W   = $clog2(TRAIN_PER_IMAGE);
	localparam int unsigned DIST_W    = 9;
	localparam int unsigned CAND_W    = 2;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned PCT_W     = 7;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned PROD_W    = 16;

	localparam logic [PCT_W-1:0] RATIO_DIFF_RST = PCT_W'(75);
	localparam logic [PCT_W-1:0] RATIO_SAME_RST = PCT_W'(85);
	localparam logic [PCT_W-1:0] PCT_SCALE      = PCT_W'(100);

	localparam logic [CFG_IDX_W-1:0] REG_RATIO_DIFF = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_SAME = CFG_IDX_W'(1);

	localparam logic [CAND_W-1:0] CAND_NONE = CAND_W'(0);
	localparam logic [CAND_W-1:0] CAND_ONE  = CAND_W'(1);

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED = 3'd0,
		ST_NONE     = 3'd1,
		ST_RATIO    = 3'd2,
		ST_DUP      = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_CHECK,
		S_SCAN,
		S_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic [QUERY_W-1:0] query;
		logic [IMG_W-1:0]   image;
		logic [TRAIN_W-1:0] train;
	} entry_t;

	typedef struct packed {
		logic   launch;
		logic   store;
		entry_t key;
	} chain_ctl_t;

	typedef struct packed {
		logic valid;
		logic dup;
	} chain_sts_t;

	typedef struct packed {
		logic [PCT_W-1:0] diff_pct;
		logic [PCT_W-1:0] same_pct;
	} ratio_cfg_t;

endpackage

/* src/rtmf_intf.sv */
// ----------------------------------------------------------------------------
// rtmf channel interfaces
// configuration write channel, match request channel and result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rtmf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rtmf_pkg::CFG_IDX_W-1:0] index;
	logic [rtmf_pkg::PCT_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface rtmf_req_if;
	logic                         valid;
	logic                         ready;
	logic                         frame_start;
	logic [rtmf_pkg::CAND_W-1:0]  cand_count;
	logic [rtmf_pkg::DIST_W-1:0]  best_distance;
	logic [rtmf_pkg::DIST_W-1:0]  second_distance;
	logic [rtmf_pkg::IMG_W-1:0]   best_image;
	logic [rtmf_pkg::IMG_W-1:0]   second_image;
	logic [rtmf_pkg::TRAIN_W-1:0] best_train_index;
	logic [rtmf_pkg::QUERY_W-1:0] query_index;

	modport source (output valid, frame_start, cand_count, best_distance, second_distance,
		best_image, second_image, best_train_index, query_index, input ready);
	modport sink (input valid, frame_start, cand_count, best_distance, second_distance,
		best_image, second_image, best_train_index, query_index, output ready);
endinterface

interface rtmf_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rtmf_pkg::STATUS_W-1:0] status;
	logic [rtmf_pkg::QUERY_W-1:0]  out_query_index;
	logic [rtmf_pkg::TRAIN_W-1:0]  out_train_index;
	logic [rtmf_pkg::IMG_W-1:0]    out_image;
	logic [rtmf_pkg::DIST_W-1:0]   out_distance;

	modport source (output valid, status, out_query_index, out_train_index, out_image,
		out_distance, input ready);
	modport sink (input valid, status, out_query_index, out_train_index, out_image,
		out_distance, output ready);
endinterface

/* src/ratio_test_match_filter.sv */
// ----------------------------------------------------------------------------
// ratio_test_match_filter
// ratio test and duplicate suppression of nearest-neighbor match candidates
// ----------------------------------------------------------------------------
// channels: cfg writes the two ratio thresholds (index 0 different images,
//   index 1 same image), always ready; req carries one query's two nearest
//   candidates; rsp returns one word per request with status and the match.
// one request is handled at a time. the result word is loaded into the rsp
//   register in the FIN state after the MUL and CHECK states when no table
//   scan is needed; a two-candidate request that passes the ratio test against
//   a non-empty table first walks a probe token up the row of table cells, one
//   cell a cycle, in the SCAN state. the next request is taken only once the
//   result is loaded into the rsp register.
// the accepted table is a row of TABLE_DEPTH cells; a new entry enters at the
//   top and the row shifts down, so the valid entries are the top cells.
// reset restores the default thresholds and empties the table by clearing
//   the entry count; no clearing pass is needed.
// a stalled rsp holds its word; the next request may be accepted meanwhile
//   and finishes once the rsp register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ratio_test_match_filter #(
	parameter int unsigned TABLE_DEPTH = rtmf_pkg::TABLE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	rtmf_cfg_if.sink   cfg,
	rtmf_req_if.sink   req,
	rtmf_rsp_if.source rsp
);

	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	rtmf_pkg::ratio_cfg_t ratio_q;
	rtmf_pkg::chain_ctl_t ctl;
	rtmf_pkg::chain_sts_t tail;
	logic [CNT_W-1:0]     count;

	rtmf_pkg::entry_t     entry_w [TABLE_DEPTH+1];
	logic [TABLE_DEPTH:0] pv_w;
	logic [TABLE_DEPTH:0] pd_w;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q.diff_pct <= rtmf_pkg::RATIO_DIFF_RST;
			ratio_q.same_pct <= rtmf_pkg::RATIO_SAME_RST;
		end else if (cfg.valid) begin
			if (cfg.index == rtmf_pkg::REG_RATIO_DIFF) begin
				ratio_q.diff_pct <= cfg.data;
			end else if (cfg.index == rtmf_pkg::REG_RATIO_SAME) begin
				ratio_q.same_pct <= cfg.data;
			end
		end
	end

	rtmf_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.ratio  (ratio_q),
		.tail   (tail),
		.ctl    (ctl),
		.count  (count)
	);

	// entries move down the row, the probe token moves up
	assign entry_w[TABLE_DEPTH] = ctl.key;
	assign pv_w[0]              = 1'b0;
	assign pd_w[0]              = 1'b0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		rtmf_cell #(
			.DEPTH (TABLE_DEPTH),
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk             (clk),
			.arst_n          (arst_n),
			.count           (count),
			.ctl             (ctl),
			.entry_in        (entry_w[i+1]),
			.entry_out       (entry_w[i]),
			.probe_valid_in  (pv_w[i]),
			.probe_dup_in    (pd_w[i]),
			.probe_valid_out (pv_w[i+1]),
			.probe_dup_out   (pd_w[i+1])
		);
	end

	assign tail.valid = pv_w[TABLE_DEPTH];
	assign tail.dup   = pd_w[TABLE_DEPTH];

	`RTMF_ASSERT(a_one_probe, clk, arst_n, $onehot0(pv_w[TABLE_DEPTH:1]),
		"more than one probe token in the row")
	`RTMF_ASSERT_NEXT(a_probe_from_launch, clk, arst_n, !ctl.launch && (pv_w[TABLE_DEPTH:1] == '0),
		pv_w[TABLE_DEPTH:1] == '0, "probe token appeared without a launch")

endmodule

/* src/rtmf_cell.sv */
// ----------------------------------------------------------------------------
// rtmf_cell
// one table slot: holds an accepted entry and checks the passing probe token
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtmf_cell #(
	parameter int unsigned DEPTH = rtmf_pkg::TABLE_DEPTH,
	parameter int unsigned IDX   = 0,
	parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CNT_W-1:0]     count,
	input  rtmf_pkg::chain_ctl_t ctl,
	input  rtmf_pkg::entry_t     entry_in,
	output rtmf_pkg::entry_t     entry_out,
	input  logic                 probe_valid_in,
	input  logic                 probe_dup_in,
	output logic                 probe_valid_out,
	output logic                 probe_dup_out
);

	rtmf_pkg::entry_t entry_q;
	logic             pv_q;
	logic             pd_q;
	logic             inject;
	logic             hit;

	// valid slots are the top count cells, so the scan starts at the lowest one
	assign inject = ctl.launch && (count == CNT_W'(DEPTH - IDX));

	assign hit = (entry_q.query == ctl.key.query) ||
		((entry_q.image == ctl.key.image) && (entry_q.train == ctl.key.train));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
			pd_q <= 1'b0;
		end else begin
			pv_q <= inject | probe_valid_in;
			pd_q <= inject ? 1'b0 : probe_dup_in;
		end
	end

	// new entries enter at the top and the row shifts down by one
	always_ff @(posedge clk) begin
		if (ctl.store) begin
			entry_q <= entry_in;
		end
	end

	assign entry_out       = entry_q;
	assign probe_valid_out = pv_q;
	assign probe_dup_out   = pd_q | (pv_q & hit);

endmodule

/* src/rtmf_ctrl.sv */
// ----------------------------------------------------------------------------
// rtmf_ctrl
// item sequencer: ratio test, scan launch, table count and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtmf_ctrl #(
	parameter int unsigned DEPTH = rtmf_pkg::TABLE_DEPTH,
	parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rtmf_req_if.sink             req,
	rtmf_rsp_if.source           rsp,
	input  rtmf_pkg::ratio_cfg_t ratio,
	input  rtmf_pkg::chain_sts_t tail,
	output rtmf_pkg::chain_ctl_t ctl,
	output logic [CNT_W-1:0]     count
);

	rtmf_pkg::ctrl_state_t state_q, state_d;

	logic [rtmf_pkg::CAND_W-1:0]  cand_q;
	logic [rtmf_pkg::DIST_W-1:0]  bd_q;
	logic [rtmf_pkg::DIST_W-1:0]  sd_q;
	logic [rtmf_pkg::IMG_W-1:0]   bi_q;
	logic [rtmf_pkg::IMG_W-1:0]   si_q;
	logic [rtmf_pkg::TRAIN_W-1:0] bt_q;
	logic [rtmf_pkg::QUERY_W-1:0] qi_q;

	logic [rtmf_pkg::PROD_W-1:0] prod_best_q;
	logic [rtmf_pkg::PROD_W-1:0] prod_thr_q;
	logic [rtmf_pkg::PCT_W-1:0]  thr;

	rtmf_pkg::status_t status_q;
	rtmf_pkg::status_t fin_status;
	logic              store_q;
	logic [CNT_W-1:0]  count_q;
	logic              full;
	logic              two_cand;
	logic              ratio_ok;

	logic rsp_valid_q;
	logic req_acc;
	logic launch;
	logic rsp_load;
	logic store;

	logic [rtmf_pkg::STATUS_W-1:0] rsp_status_q;
	logic [rtmf_pkg::QUERY_W-1:0]  rsp_query_q;
	logic [rtmf_pkg::TRAIN_W-1:0]  rsp_train_q;
	logic [rtmf_pkg::IMG_W-1:0]    rsp_image_q;
	logic [rtmf_pkg::DIST_W-1:0]   rsp_dist_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign two_cand = (cand_q != rtmf_pkg::CAND_NONE) && (cand_q != rtmf_pkg::CAND_ONE);
	assign ratio_ok = (prod_best_q < prod_thr_q);
	assign thr      = (bi_q == si_q) ? ratio.same_pct : ratio.diff_pct;
	assign req_acc  = req.valid && req.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rtmf_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = rtmf_pkg::S_MUL;
				end
			end
			rtmf_pkg::S_MUL: begin
				state_d = rtmf_pkg::S_CHECK;
			end
			rtmf_pkg::S_CHECK: begin
				if (two_cand && ratio_ok && (count_q != '0)) begin
					state_d = rtmf_pkg::S_SCAN;
				end else begin
					state_d = rtmf_pkg::S_FIN;
				end
			end
			rtmf_pkg::S_SCAN: begin
				if (tail.valid) begin
					state_d = rtmf_pkg::S_FIN;
				end
			end
			rtmf_pkg::S_FIN: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = rtmf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rtmf_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		launch    = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			rtmf_pkg::S_IDLE: begin
				req.ready = 1'b1;
			end
			rtmf_pkg::S_CHECK: begin
				launch = two_cand && ratio_ok && (count_q != '0);
			end
			rtmf_pkg::S_FIN: begin
				rsp_load = !rsp_valid_q || rsp.ready;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	assign store      = rsp_load && store_q && !full;
	assign fin_status = store_q ? (full ? rtmf_pkg::ST_FULL : rtmf_pkg::ST_ACCEPTED) : status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rtmf_pkg::S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_acc && req.frame_start) begin
				count_q <= '0;
			end else if (store) begin
				count_q <= count_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cand_q <= req.cand_count;
			bd_q   <= req.best_distance;
			sd_q   <= req.second_distance;
			bi_q   <= req.best_image;
			si_q   <= req.second_image;
			bt_q   <= req.best_train_index;
			qi_q   <= req.query_index;
		end
		if (state_q == rtmf_pkg::S_MUL) begin
			prod_best_q <= rtmf_pkg::PROD_W'(bd_q) * rtmf_pkg::PROD_W'(rtmf_pkg::PCT_SCALE);
			prod_thr_q  <= rtmf_pkg::PROD_W'(thr) * rtmf_pkg::PROD_W'(sd_q);
		end
		if (state_q == rtmf_pkg::S_CHECK) begin
			if (cand_q == rtmf_pkg::CAND_NONE) begin
				status_q <= rtmf_pkg::ST_NONE;
				store_q  <= 1'b0;
			end else if (two_cand && !ratio_ok) begin
				status_q <= rtmf_pkg::ST_RATIO;
				store_q  <= 1'b0;
			end else begin
				status_q <= rtmf_pkg::ST_ACCEPTED;
				store_q  <= 1'b1;
			end
		end
		if ((state_q == rtmf_pkg::S_SCAN) && tail.valid && tail.dup) begin
			status_q <= rtmf_pkg::ST_DUP;
			store_q  <= 1'b0;
		end
		if (rsp_load) begin
			rsp_status_q <= fin_status;
			rsp_query_q  <= qi_q;
			// no candidate reports a cleared match
			if (cand_q == rtmf_pkg::CAND_NONE) begin
				rsp_train_q <= '0;
				rsp_image_q <= '0;
				rsp_dist_q  <= '0;
			end else begin
				rsp_train_q <= bt_q;
				rsp_image_q <= bi_q;
				rsp_dist_q  <= bd_q;
			end
		end
	end

	assign ctl.launch          = launch;
	assign ctl.store           = store;
	assign ctl.key.query       = qi_q;
	assign ctl.key.image       = bi_q;
	assign ctl.key.train       = bt_q;
	assign count               = count_q;

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.out_query_index = rsp_query_q;
	assign rsp.out_train_index = rsp_train_q;
	assign rsp.out_image       = rsp_image_q;
	assign rsp.out_distance    = rsp_dist_q;

	`RTMF_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "count above table depth")
	`RTMF_ASSERT(a_tail_in_scan, clk, arst_n, !tail.valid || (state_q == rtmf_pkg::S_SCAN),
		"probe left the row outside a scan")
	`RTMF_ASSERT_NEXT(a_store_grows, clk, arst_n, store, count_q == $past(count_q) + 1'b1,
		"store did not advance the count")

endmodule

/* sim/tb_ratio_test_match_filter.sv */
// ----------------------------------------------------------------------------
// tb_ratio_test_match_filter
// self-checking bench for the ratio test match filter: every accepted request
// is run through a behavioral predictor (ratio test, duplicate scan, table
// fill) and the expected words are compared field by field with each result
// word taken from the rsp channel, under several sender and receiver idling
// mixes and one long receiver hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ratio_test_match_filter;

	localparam int unsigned LIMIT_CYCLES    = 2000000;
	localparam int unsigned SETTLE_CYCLES   = 300;
	localparam int unsigned HOLD_CYCLES     = 300;
	localparam int unsigned WORDS_PER_PHASE = 240;
	localparam int unsigned MAX_REPORTS     = 40;

	localparam logic [rtmf_pkg::CAND_W-1:0] CAND_TWO  = rtmf_pkg::CAND_W'(2);
	localparam logic [rtmf_pkg::CAND_W-1:0] CAND_MANY = rtmf_pkg::CAND_W'(3);

	localparam logic [rtmf_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = rtmf_pkg::CFG_IDX_W'(2);
	localparam logic [rtmf_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = rtmf_pkg::CFG_IDX_W'(15);

	typedef struct {
		logic                         frame_start;
		logic [rtmf_pkg::CAND_W-1:0]  cand_count;
		logic [rtmf_pkg::DIST_W-1:0]  best_distance;
		logic [rtmf_pkg::DIST_W-1:0]  second_distance;
		logic [rtmf_pkg::IMG_W-1:0]   best_image;
		logic [rtmf_pkg::IMG_W-1:0]   second_image;
		logic [rtmf_pkg::TRAIN_W-1:0] best_train_index;
		logic [rtmf_pkg::QUERY_W-1:0] query_index;
	} match_req_t;

	typedef struct {
		rtmf_pkg::status_t            status;
		logic [rtmf_pkg::QUERY_W-1:0] query_index;
		logic [rtmf_pkg::TRAIN_W-1:0] train_index;
		logic [rtmf_pkg::IMG_W-1:0]   image;
		logic [rtmf_pkg::DIST_W-1:0]  distance;
	} match_rsp_t;

	logic clk;
	logic arst_n;

	rtmf_cfg_if cfg_if();
	rtmf_req_if req_if();
	rtmf_rsp_if rsp_if();

	ratio_test_match_filter u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_if),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// predictor state
	logic [rtmf_pkg::PCT_W-1:0] thr_diff = rtmf_pkg::RATIO_DIFF_RST;
	logic [rtmf_pkg::PCT_W-1:0] thr_same = rtmf_pkg::RATIO_SAME_RST;
	rtmf_pkg::entry_t           match_table [rtmf_pkg::TABLE_DEPTH];
	int unsigned                match_count = 0;

	match_rsp_t  pending_results[$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	logic        hold_req;
	int unsigned hold_left = 0;
	bit          hold_taken = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rtmf_pkg::status_t store_match(input match_req_t m);
		if (match_count >= rtmf_pkg::TABLE_DEPTH)
			return rtmf_pkg::ST_FULL;
		match_table[match_count] = '{query: m.query_index, image: m.best_image,
			train: m.best_train_index};
		match_count++;
		return rtmf_pkg::ST_ACCEPTED;
	endfunction

	function automatic match_rsp_t predict_match(input match_req_t m);
		match_rsp_t                 r;
		logic [rtmf_pkg::PCT_W-1:0] thr;
		int unsigned                lhs;
		int unsigned                rhs;
		bit                         dup;
		r.query_index = m.query_index;
		r.train_index = m.best_train_index;
		r.image       = m.best_image;
		r.distance    = m.best_distance;
		if (m.frame_start)
			match_count = 0;
		if (m.cand_count == rtmf_pkg::CAND_NONE) begin
			r.status      = rtmf_pkg::ST_NONE;
			r.train_index = '0;
			r.image       = '0;
			r.distance    = '0;
		end else if (m.cand_count == rtmf_pkg::CAND_ONE) begin
			r.status = store_match(m);
		end else begin
			thr = (m.best_image == m.second_image) ? thr_same : thr_diff;
			lhs = int'(m.best_distance) * int'(rtmf_pkg::PCT_SCALE);
			rhs = int'(thr) * int'(m.second_distance);
			dup = 1'b0;
			for (int unsigned i = 0; i < match_count; i++) begin
				if (match_table[i].query == m.query_index)
					dup = 1'b1;
				if (match_table[i].train == m.best_train_index &&
						match_table[i].image == m.best_image)
					dup = 1'b1;
			end
			if (lhs >= rhs)
				r.status = rtmf_pkg::ST_RATIO;
			else if (dup)
				r.status = rtmf_pkg::ST_DUP;
			else
				r.status = store_match(m);
		end
		return r;
	endfunction

	function automatic match_req_t mk_match(input int unsigned fs,
			input logic [rtmf_pkg::CAND_W-1:0] cnt,
			input int unsigned bd, input int unsigned sd, input int unsigned bi,
			input int unsigned si, input int unsigned tr, input int unsigned q);
		match_req_t m;
		m.frame_start      = fs[0];
		m.cand_count       = cnt;
		m.best_distance    = rtmf_pkg::DIST_W'(bd);
		m.second_distance  = rtmf_pkg::DIST_W'(sd);
		m.best_image       = rtmf_pkg::IMG_W'(bi);
		m.second_image     = rtmf_pkg::IMG_W'(si);
		m.best_train_index = rtmf_pkg::TRAIN_W'(tr);
		m.query_index      = rtmf_pkg::QUERY_W'(q);
		return m;
	endfunction

	function automatic int unsigned rand_dist();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 0;
		if (pick == 1)
			return 256;
		return $urandom_range(0, 256);
	endfunction

	function automatic int unsigned rand_pct();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 0;
		if (pick == 1)
			return 100;
		if (pick == 2)
			return 127;
		return $urandom_range(50, 100);
	endfunction

	// mostly well-formed candidates over small key pools so duplicates are common,
	// the rest noise over the full index ranges with distances up to 256
	function automatic match_req_t rand_match();
		match_req_t  m;
		int unsigned pick;
		int unsigned sd;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			m = mk_match(($urandom_range(0, 19) == 0),
				rtmf_pkg::CAND_W'($urandom_range(0, 3)),
				rand_dist(), rand_dist(), $urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 1023), $urandom_range(0, 255));
		end else begin
			sd = $urandom_range(1, 256);
			m = mk_match(($urandom_range(0, 29) == 0),
				(pick < 20) ? rtmf_pkg::CAND_ONE : ((pick < 30) ? CAND_MANY : CAND_TWO),
				$urandom_range(0, sd), sd, $urandom_range(0, 3), 0,
				$urandom_range(0, 15), $urandom_range(0, 47));
			m.second_image = $urandom_range(0, 1) ? m.best_image :
				rtmf_pkg::IMG_W'($urandom_range(0, 63));
		end
		return m;
	endfunction

	task automatic send_match(input match_req_t m);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid            <= 1'b1;
		req_if.frame_start      <= m.frame_start;
		req_if.cand_count       <= m.cand_count;
		req_if.best_distance    <= m.best_distance;
		req_if.second_distance  <= m.second_distance;
		req_if.best_image       <= m.best_image;
		req_if.second_image     <= m.second_image;
		req_if.best_train_index <= m.best_train_index;
		req_if.query_index      <= m.query_index;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		pending_results = {pending_results, predict_match(m)};
	endtask

	task automatic write_reg(input logic [rtmf_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= rtmf_pkg::PCT_W'(val);
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		if (idx == rtmf_pkg::REG_RATIO_DIFF)
			thr_diff = rtmf_pkg::PCT_W'(val);
		else if (idx == rtmf_pkg::REG_RATIO_SAME)
			thr_same = rtmf_pkg::PCT_W'(val);
		@(posedge clk);
	endtask

	task automatic wait_results_done();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_cases();
		wait_results_done();
		send_match(mk_match(1, rtmf_pkg::CAND_NONE, 256, 256, 63, 63, 1023, 255));
		send_match(mk_match(0, rtmf_pkg::CAND_ONE, 256, 0, 63, 0, 1023, 255));
		// just under and exactly at the different-image threshold
		send_match(mk_match(0, CAND_TWO, 74, 100, 1, 2, 10, 1));
		send_match(mk_match(0, CAND_TWO, 75, 100, 1, 2, 11, 2));
		// same pair of checks against the same-image threshold
		send_match(mk_match(0, CAND_TWO, 84, 100, 3, 3, 12, 3));
		send_match(mk_match(0, CAND_TWO, 85, 100, 3, 3, 13, 4));
		// zero second distance can never pass
		send_match(mk_match(0, CAND_TWO, 0, 0, 4, 5, 14, 5));
		send_match(mk_match(0, CAND_TWO, 0, 1, 4, 5, 14, 5));
		// duplicate by query, then by train index and image, then same train other image
		send_match(mk_match(0, CAND_TWO, 10, 200, 9, 8, 20, 1));
		send_match(mk_match(0, CAND_TWO, 10, 200, 1, 8, 10, 6));
		send_match(mk_match(0, CAND_TWO, 10, 200, 2, 8, 10, 6));
		send_match(mk_match(0, CAND_MANY, 10, 200, 6, 7, 30, 7));
		send_match(mk_match(0, CAND_MANY, 190, 200, 6, 7, 31, 8));
		// single candidate skips the duplicate scan
		send_match(mk_match(0, rtmf_pkg::CAND_ONE, 5, 0, 6, 0, 30, 7));
		send_match(mk_match(0, CAND_TWO, 256, 256, 0, 0, 0, 0));
		// new frame forgets earlier matches
		send_match(mk_match(1, CAND_TWO, 10, 200, 1, 2, 10, 1));
		send_match(mk_match(0, CAND_TWO, 0, 256, 0, 63, 0, 0));
		send_match(mk_match(0, rtmf_pkg::CAND_ONE, 0, 256, 0, 63, 0, 0));
		send_match(mk_match(1, rtmf_pkg::CAND_NONE, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_threshold_extremes();
		wait_results_done();
		write_reg(rtmf_pkg::REG_RATIO_DIFF, 0);
		write_reg(rtmf_pkg::REG_RATIO_SAME, 127);
		// writes to unused indexes must leave both thresholds alone
		write_reg(REG_UNUSED_LO, 1);
		write_reg(REG_UNUSED_HI, 5);
		send_match(mk_match(1, CAND_TWO, 0, 256, 1, 2, 40, 10));
		send_match(mk_match(0, CAND_TWO, 256, 256, 5, 5, 100, 10));
		send_match(mk_match(0, CAND_TWO, 127, 100, 5, 5, 101, 11));
		send_match(mk_match(0, CAND_TWO, 126, 100, 5, 5, 102, 12));
		wait_results_done();
		write_reg(rtmf_pkg::REG_RATIO_DIFF, 100);
		write_reg(rtmf_pkg::REG_RATIO_SAME, 0);
		send_match(mk_match(0, CAND_TWO, 99, 100, 1, 2, 103, 13));
		send_match(mk_match(0, CAND_TWO, 100, 100, 1, 2, 104, 14));
		send_match(mk_match(0, CAND_TWO, 0, 256, 3, 3, 105, 15));
	endtask

	task automatic test_table_full();
		wait_results_done();
		write_reg(rtmf_pkg::REG_RATIO_DIFF, rtmf_pkg::RATIO_DIFF_RST);
		write_reg(rtmf_pkg::REG_RATIO_SAME, rtmf_pkg::RATIO_SAME_RST);
		send_idle_pct = 0;
		stall_pct     = 0;
		for (int unsigned i = 0; i < rtmf_pkg::TABLE_DEPTH; i++)
			send_match(mk_match(i == 0, rtmf_pkg::CAND_ONE, i, 0, i % 64, 0, i, 7));
		send_match(mk_match(0, rtmf_pkg::CAND_ONE, 3, 0, 1, 0, 900, 200));
		// passes the ratio test and the full scan, then finds no room
		send_match(mk_match(0, CAND_TWO, 10, 200, 5, 6, 1000, 9));
		send_match(mk_match(0, CAND_TWO, 10, 200, 5, 6, 1001, 7));
		// hit on the most recently stored entry
		send_match(mk_match(0, CAND_TWO, 10, 200, 63, 6, 255, 9));
		send_match(mk_match(0, CAND_TWO, 190, 200, 5, 6, 1002, 9));
		send_match(mk_match(0, rtmf_pkg::CAND_NONE, 10, 200, 5, 6, 1003, 9));
		send_match(mk_match(1, rtmf_pkg::CAND_ONE, 10, 200, 5, 6, 1004, 7));
	endtask

	task automatic test_output_backpressure();
		wait_results_done();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req <= 1'b1;
		send_match(mk_match(1, CAND_TWO, 10, 200, 1, 2, 500, 20));
		for (int unsigned i = 0; i < 9; i++)
			send_match(rand_match());
		hold_req <= 1'b0;
	endtask

	task automatic test_random_traffic();
		int unsigned idle_mix [4] = '{0, 59, 0, 21};
		int unsigned stall_mix [4] = '{0, 0, 59, 21};
		for (int p = 0; p < 4; p++) begin
			wait_results_done();
			write_reg(rtmf_pkg::REG_RATIO_DIFF, rand_pct());
			write_reg(rtmf_pkg::REG_RATIO_SAME, rand_pct());
			send_idle_pct = idle_mix[p];
			stall_pct     = stall_mix[p];
			for (int unsigned i = 0; i < WORDS_PER_PHASE; i++)
				send_match(rand_match());
		end
	endtask

	task automatic report_field(input string fld, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, exp_val, got_val);
	endtask

	// receiver: random stalls, or a long hold-off counted here once requested
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_left  = HOLD_CYCLES;
			hold_taken = 1'b1;
		end else if (!hold_req) begin
			hold_taken = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		match_rsp_t exp_word;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected result word, expected none, got status %0d query %0d",
						$time, rsp_if.status, rsp_if.out_query_index);
			end else begin
				exp_word = pending_results.pop_front();
				if (rsp_if.status !== exp_word.status)
					report_field("status", exp_word.status, rsp_if.status);
				if (rsp_if.out_query_index !== exp_word.query_index)
					report_field("out_query_index", exp_word.query_index,
						rsp_if.out_query_index);
				if (rsp_if.out_train_index !== exp_word.train_index)
					report_field("out_train_index", exp_word.train_index,
						rsp_if.out_train_index);
				if (rsp_if.out_image !== exp_word.image)
					report_field("out_image", exp_word.image, rsp_if.out_image);
				if (rsp_if.out_distance !== exp_word.distance)
					report_field("out_distance", exp_word.distance, rsp_if.out_distance);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n                  <= 1'b0;
		hold_req                <= 1'b0;
		cfg_if.valid            <= 1'b0;
		cfg_if.index            <= '0;
		cfg_if.data             <= '0;
		req_if.valid            <= 1'b0;
		req_if.frame_start      <= 1'b0;
		req_if.cand_count       <= '0;
		req_if.best_distance    <= '0;
		req_if.second_distance  <= '0;
		req_if.best_image       <= '0;
		req_if.second_image     <= '0;
		req_if.best_train_index <= '0;
		req_if.query_index      <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_threshold_extremes();
		test_table_full();
		test_output_backpressure();
		test_random_traffic();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/rtmf_pkg.sv
src/rtmf_intf.sv
src/rtmf_cell.sv
src/rtmf_ctrl.sv
src/ratio_test_match_filter.sv
sim/tb_ratio_test_match_filter.sv
